// File: sv/dsx2_pkg.sv
// ----------------------------------------------------------------------------
// dsx2_pkg: shared types and constants for the 2:1 image reducer
// Sizes of the line store, column counter and channel slots.
// ----------------------------------------------------------------------------
package dsx2_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int SW_W       = 12;
    localparam int CNT_W      = COL_W + 1;
    localparam int CMP_W      = (CNT_W > SW_W) ? CNT_W : SW_W;
    localparam int PIX_W      = 8;
    localparam int SLOT_W     = PIX_W + 1;
    localparam int NCH        = 3;
    localparam int WORD_W     = NCH * SLOT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SW_W;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_MODE  = 2'd1;

    localparam logic [SW_W-1:0] SOURCE_WIDTH_RESET = 12'd640;
    localparam logic            REDUCE_MODE_RESET  = 1'b1;

    localparam logic MODE_NEAREST = 1'b0;
    localparam logic MODE_AVERAGE = 1'b1;

    // one accepted pixel as seen by the output stage
    typedef struct packed {
        logic                              has_res;
        logic                              mode;
        logic                              line_last;
        logic [NCH-1:0][SLOT_W-1:0]        bot;
    } t_step;

endpackage

// File: sv/dsx2_ram.sv
// ----------------------------------------------------------------------------
// dsx2_ram: simple dual-port RAM
// One write port, one read port with read enable and registered data.
// ----------------------------------------------------------------------------
module dsx2_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/dsx2_ctl.sv
// ----------------------------------------------------------------------------
// dsx2_ctl: position tracking and line store access
// Holds the registers, column and row state and the pending even-column
// pixel; builds the line store word and the step record for each request.
// ----------------------------------------------------------------------------
module dsx2_ctl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [dsx2_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dsx2_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_accept,
    input  logic [dsx2_pkg::PIX_W-1:0]       i_pix_red,
    input  logic [dsx2_pkg::PIX_W-1:0]       i_pix_green,
    input  logic [dsx2_pkg::PIX_W-1:0]       i_pix_blue,
    input  logic                             i_frame_start,
    output logic                             o_we,
    output logic                             o_re,
    output logic [dsx2_pkg::ADDR_W-1:0]      o_addr,
    output logic [dsx2_pkg::WORD_W-1:0]      o_wdata,
    output dsx2_pkg::t_step                  o_step
);

    logic [dsx2_pkg::SW_W-1:0]            r_src_width;
    logic                                 r_mode;
    logic [dsx2_pkg::COL_W-1:0]           r_col, n_col;
    logic                                 r_row_odd, n_row_odd;
    logic [dsx2_pkg::NCH*dsx2_pkg::PIX_W-1:0] r_pending, n_pending;

    logic [dsx2_pkg::NCH-1:0][dsx2_pkg::PIX_W-1:0] px;
    logic [dsx2_pkg::COL_W-1:0]           col;
    logic                                 row;
    logic [dsx2_pkg::CMP_W-1:0]           sw_ext, eff_w, col_next;

    assign px  = {i_pix_blue, i_pix_green, i_pix_red};
    assign col = i_frame_start ? '0 : r_col;
    assign row = i_frame_start ? 1'b0 : r_row_odd;

    always_comb begin
        sw_ext = dsx2_pkg::CMP_W'(r_src_width);
        if (sw_ext > dsx2_pkg::CMP_W'(dsx2_pkg::MAX_WIDTH)) begin
            eff_w = dsx2_pkg::CMP_W'(dsx2_pkg::MAX_WIDTH);
        end else if (sw_ext < dsx2_pkg::CMP_W'(2)) begin
            eff_w = dsx2_pkg::CMP_W'(2);
        end else begin
            eff_w = sw_ext;
        end
    end

    assign col_next = dsx2_pkg::CMP_W'(col) + dsx2_pkg::CMP_W'(1);

    always_comb begin
        o_we    = i_accept & col[0] & ~row;
        o_re    = i_accept & col[0] & row;
        o_addr  = dsx2_pkg::ADDR_W'(col >> 1);
        o_wdata = '0;
        for (int ch = 0; ch < dsx2_pkg::NCH; ch++) begin
            o_step.bot[ch] = dsx2_pkg::SLOT_W'(r_pending[ch*dsx2_pkg::PIX_W +: dsx2_pkg::PIX_W])
                           + dsx2_pkg::SLOT_W'(px[ch]);
            // nearest mode keeps the top-left pixel in the slot
            if (r_mode == dsx2_pkg::MODE_AVERAGE) begin
                o_wdata[ch*dsx2_pkg::SLOT_W +: dsx2_pkg::SLOT_W] = o_step.bot[ch];
            end else begin
                o_wdata[ch*dsx2_pkg::SLOT_W +: dsx2_pkg::SLOT_W] =
                    dsx2_pkg::SLOT_W'(r_pending[ch*dsx2_pkg::PIX_W +: dsx2_pkg::PIX_W]);
            end
        end
        o_step.has_res   = col[0] & row;
        o_step.mode      = r_mode;
        o_step.line_last = (col_next == {eff_w[dsx2_pkg::CMP_W-1:1], 1'b0});
    end

    always_comb begin
        n_col     = r_col;
        n_row_odd = r_row_odd;
        n_pending = r_pending;
        if (i_accept) begin
            if (!col[0]) begin
                n_pending = px;
            end
            if (col_next >= eff_w) begin
                n_col     = '0;
                n_row_odd = ~row;
            end else begin
                n_col     = dsx2_pkg::COL_W'(col_next);
                n_row_odd = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width <= dsx2_pkg::SOURCE_WIDTH_RESET;
            r_mode      <= dsx2_pkg::REDUCE_MODE_RESET;
            r_col       <= '0;
            r_row_odd   <= 1'b0;
            r_pending   <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    dsx2_pkg::REG_SOURCE_WIDTH: r_src_width <= i_cfg_data;
                    dsx2_pkg::REG_REDUCE_MODE:  r_mode      <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_col     <= n_col;
            r_row_odd <= n_row_odd;
            r_pending <= n_pending;
        end
    end

endmodule

// File: sv/dsx2_out.sv
// ----------------------------------------------------------------------------
// dsx2_out: result stage and output register
// Joins the line store read data with the bottom pair sums and holds the
// reduced pixel until the receiver takes it.
// ----------------------------------------------------------------------------
module dsx2_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  dsx2_pkg::t_step               i_step,
    input  logic [dsx2_pkg::WORD_W-1:0]   i_rdata,
    output logic                          o_in_ready,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dsx2_pkg::PIX_W-1:0]    o_out_red,
    output logic [dsx2_pkg::PIX_W-1:0]    o_out_green,
    output logic [dsx2_pkg::PIX_W-1:0]    o_out_blue,
    output logic                          o_line_last
);

    logic                                       r_s1_v;
    dsx2_pkg::t_step                            r_s1;
    logic                                       r_o_v;
    logic [dsx2_pkg::NCH-1:0][dsx2_pkg::PIX_W-1:0] r_pix, n_pix;
    logic                                       r_last;
    logic                                       s1_fire, load;
    logic [dsx2_pkg::SLOT_W-1:0]                s;
    logic [dsx2_pkg::SLOT_W:0]                  sum;

    // read data stays put while a result waits here: no read is issued
    assign load       = r_s1_v & r_s1.has_res & (~r_o_v | i_ready);
    assign s1_fire    = r_s1_v & (~r_s1.has_res | ~r_o_v | i_ready);
    assign o_in_ready = ~r_s1_v | s1_fire;

    always_comb begin
        s   = '0;
        sum = '0;
        for (int ch = 0; ch < dsx2_pkg::NCH; ch++) begin
            s   = i_rdata[ch*dsx2_pkg::SLOT_W +: dsx2_pkg::SLOT_W];
            sum = (dsx2_pkg::SLOT_W + 1)'(s) + (dsx2_pkg::SLOT_W + 1)'(r_s1.bot[ch]);
            if (r_s1.mode == dsx2_pkg::MODE_AVERAGE) begin
                n_pix[ch] = sum[dsx2_pkg::SLOT_W:2];
            end else begin
                n_pix[ch] = s[dsx2_pkg::PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end
            if (load) begin
                r_o_v <= 1'b1;
            end else if (i_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_step;
        end
        if (load) begin
            r_pix  <= n_pix;
            r_last <= r_s1.line_last;
        end
    end

    assign o_valid     = r_o_v;
    assign o_out_red   = r_pix[0];
    assign o_out_green = r_pix[1];
    assign o_out_blue  = r_pix[2];
    assign o_line_last = r_last;

endmodule

// File: sv/image_downscale_2x_box_average.sv
// ----------------------------------------------------------------------------
// image_downscale_2x_box_average: streaming 2:1 RGB888 image reducer
// One output pixel per 2x2 source block, top-left or box average.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order on i_valid/o_ready, one request per
// cycle when the output side keeps up. i_frame_start puts a pixel at column
// 0 of an even row. Even rows only fill the line store; on odd rows each
// second pixel completes a block and yields one reduced pixel on
// o_valid/i_ready, with o_line_last on the last pixel of a reduced line.
// A block's result passes the line store read, then the output register,
// after the block's bottom-right pixel is accepted.
// Throughput: one pixel per cycle, set by the single read port of the line
// store and a one-entry result stage ahead of the output register.
// If the receiver stalls, one result waits in the output register and one
// in the result stage; o_ready then drops until the output drains.
// The config port (o_cfg_ready always high) writes source_width (index 0)
// and reduce_mode (index 1); write it only while the stream is idle.
// Reset is synchronous: position counters clear, registers return to 640
// and average mode. The line store is not cleared; even rows fill it.
// ----------------------------------------------------------------------------
module image_downscale_2x_box_average (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dsx2_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dsx2_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [dsx2_pkg::PIX_W-1:0]       i_pix_red,
    input  logic [dsx2_pkg::PIX_W-1:0]       i_pix_green,
    input  logic [dsx2_pkg::PIX_W-1:0]       i_pix_blue,
    input  logic                             i_frame_start,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [dsx2_pkg::PIX_W-1:0]       o_out_red,
    output logic [dsx2_pkg::PIX_W-1:0]       o_out_green,
    output logic [dsx2_pkg::PIX_W-1:0]       o_out_blue,
    output logic                             o_line_last
);

    logic                              accept;
    logic                              we, re;
    logic [dsx2_pkg::ADDR_W-1:0]       addr;
    logic [dsx2_pkg::WORD_W-1:0]       wdata, rdata;
    dsx2_pkg::t_step                   step;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid & o_ready;

    dsx2_ctl u_ctl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_pix_red     (i_pix_red),
        .i_pix_green   (i_pix_green),
        .i_pix_blue    (i_pix_blue),
        .i_frame_start (i_frame_start),
        .o_we          (we),
        .o_re          (re),
        .o_addr        (addr),
        .o_wdata       (wdata),
        .o_step        (step)
    );

    dsx2_ram #(
        .WIDTH (dsx2_pkg::WORD_W),
        .DEPTH (dsx2_pkg::LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    dsx2_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_step      (step),
        .i_rdata     (rdata),
        .o_in_ready  (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_line_last (o_line_last)
    );

endmodule

// File: sv/dsx2_chk.sv
// ----------------------------------------------------------------------------
// dsx2_chk: port-level checks for the 2:1 image reducer
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module dsx2_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [dsx2_pkg::PIX_W-1:0]    o_out_red,
    input  logic [dsx2_pkg::PIX_W-1:0]    o_out_green,
    input  logic [dsx2_pkg::PIX_W-1:0]    o_out_blue,
    input  logic                          o_line_last
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable({o_out_red, o_out_green, o_out_blue, o_line_last}))
        else $error("stalled result changed");

    // a fresh result is traced back to an accepted request
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result without a matching request");

    // output is empty on leaving reset
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result pending after reset");

endmodule

bind image_downscale_2x_box_average dsx2_chk u_dsx2_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue),
    .o_line_last (o_line_last)
);
